// ===== hdl/text_console_writer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text console writer
// Clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, command codes and character constants of the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CMD_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int LINE_W  = 8;
  localparam int INDEX_W = 11;
  localparam int CARET_W = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PLAIN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COLOR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // character and attribute values
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h00;
  localparam logic [CHAR_W-1:0] ATTR_DEFAULT   = 8'h07;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [CHAR_W-1:0]  color;
    logic [LINE_W-1:0]  line_count;
    logic [INDEX_W-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [CARET_W-1:0] caret;
    logic [CHAR_W-1:0]  cell_char;
    logic [CHAR_W-1:0]  cell_attr;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_WIPE,
    OP_SCROLL,
    OP_READ
  } op_kind_t;

  // classified item, as it travels from the front end to the engine
  typedef struct packed {
    op_kind_t           kind;
    logic               colored;
    logic [CHAR_W-1:0]  char_code;
    logic [CHAR_W-1:0]  color;
    logic [LINE_W-1:0]  line_count;
    logic               in_range;
    logic [INDEX_W-1:0] cell_index;
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_WIPE,
    ST_COPY,
    ST_DRAIN,
    ST_ZERO
  } back_state_t;

endpackage

// ===== hdl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request items, classifies them and holds one classified item.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tcw_pkg::req_t req,
  input  logic          hold,
  output logic          op_valid,
  output tcw_pkg::op_t  op,
  input  logic          op_full
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  op_t  op_next;
  logic take;

  assign req_stall = hold || (op_valid && op_full);
  assign take      = req_valid && !req_stall;

  always_comb begin
    op_next            = '0;
    op_next.kind       = OP_NOP;
    op_next.char_code  = req.char_code;
    op_next.color      = req.color;
    op_next.line_count = req.line_count;
    op_next.cell_index = req.cell_index;
    op_next.in_range   = 32'(req.cell_index) < 32'(CELLS);
    case (req.cmd)
      CMD_PLAIN: begin
        if (req.char_code == CHAR_NEWLINE) begin
          op_next.kind = OP_NEWLINE;
        end else if (req.char_code == CHAR_BACKSPACE) begin
          op_next.kind = OP_BACKSPACE;
        end else begin
          op_next.kind = OP_PUT;
        end
      end
      CMD_COLOR: begin
        op_next.colored = 1'b1;
        op_next.kind    = (req.char_code == CHAR_NEWLINE) ? OP_NEWLINE : OP_PUT;
      end
      CMD_CLEAR: op_next.kind = OP_WIPE;
      CMD_SCROLL: begin
        if (req.line_count == '0) begin
          op_next.kind = OP_NOP;
        end else if (32'(req.line_count) > 32'(ROWS)) begin
          op_next.kind = OP_WIPE;
        end else begin
          op_next.kind = OP_SCROLL;
        end
      end
      CMD_READ: op_next.kind = OP_READ;
      default:  op_next.kind = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (take) begin
      op_valid <= 1'b1;
    end else if (!op_full) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) op <= op_next;
  end

endmodule

// ===== hdl/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue
// Short queue of classified items between the front end and the engine.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         full,
  input  tcw_pkg::op_t push_data,
  output logic         head_valid,
  output tcw_pkg::op_t head,
  input  logic         pop
);
  import tcw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  op_t           slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          take;

  assign full       = count == CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign push       = push_valid && !full;
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      if (take) rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      if (push && !take) begin
        count <= count + CW'(1);
      end else if (take && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  `TCW_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH), "queue overfilled")
  `TCW_ASSERT_NEXT(a_push_grows, clk, rst, push && !take, count == $past(count) + CW'(1), "lost push")

endmodule

// ===== hdl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Screen engine: character and attribute memories, caret, row walks and
// the result register.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  tcw_pkg::op_t  op_head,
  output logic          op_pop,
  output logic          init_busy,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tcw_pkg::rsp_t rsp
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = AW + 1;
  localparam int COLW  = $clog2(COLUMNS);

  localparam logic [SW-1:0]   CELLS_S        = SW'(CELLS);
  localparam logic [SW-1:0]   ROW_SPAN       = SW'(COLUMNS);
  localparam logic [AW-1:0]   LAST_CELL      = AW'(CELLS - 1);
  localparam logic [AW-1:0]   LAST_ROW_START = AW'(CELLS - COLUMNS);
  localparam logic [COLW-1:0] LAST_COL       = COLW'(COLUMNS - 1);

  // screen memories
  logic [CHAR_W-1:0] chars [CELLS];
  logic [CHAR_W-1:0] attrs [CELLS];
  logic              c_we, a_we;
  logic [AW-1:0]     c_waddr, a_waddr, rd_addr;
  logic [CHAR_W-1:0] c_wdata, a_wdata, c_rdata, a_rdata;

  back_state_t       state, state_next;
  op_t               cur, cur_next;
  logic [AW-1:0]     walk, walk_next;
  logic [SW-1:0]     shift, shift_next;
  logic              wrap, wrap_next;
  logic              pend_valid, pend_valid_next;
  logic [AW-1:0]     pend_dst, pend_dst_next;
  logic [AW-1:0]     caret_pos, caret_pos_next;
  logic [COLW-1:0]   caret_col, caret_col_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic                   rsp_free;
  logic                   emit;
  logic [CHAR_W-1:0]      emit_char, emit_attr;
  logic [SW-1:0]          pos_inc, row_start, row_end, walk_inc, zero_start;
  logic [31:0]            shift_prod;
  logic [SW-1:0]          shift_req;
  logic [COLW-1:0]        col_inc;
  logic [AW-1:0]          bs_pos;
  logic [COLW-1:0]        bs_col;
  logic [INDEX_W+AW-1:0]  head_idx_wide;
  logic [CARET_W+AW-1:0]  caret_wide;

  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign init_busy  = state == ST_INIT;
  assign pos_inc    = {1'b0, caret_pos} + SW'(1);
  assign row_start  = {1'b0, caret_pos} - SW'(caret_col);
  assign row_end    = row_start + ROW_SPAN;
  assign walk_inc   = {1'b0, walk} + SW'(1);
  assign zero_start = CELLS_S - shift;
  assign shift_prod = 32'(cur.line_count) * 32'(COLUMNS);
  assign shift_req  = shift_prod[SW-1:0];
  assign col_inc    = (caret_col == LAST_COL) ? '0 : caret_col + COLW'(1);
  assign bs_pos     = (caret_pos == '0) ? '0 : caret_pos - AW'(1);
  assign bs_col     = (caret_pos == '0) ? '0 :
                      (caret_col == '0) ? LAST_COL : caret_col - COLW'(1);
  assign head_idx_wide = {{AW{1'b0}}, op_head.cell_index};
  assign caret_wide    = {{CARET_W{1'b0}}, caret_pos_next};

  always_ff @(posedge clk) begin
    if (c_we) chars[c_waddr] <= c_wdata;
    c_rdata <= chars[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (a_we) attrs[a_waddr] <= a_wdata;
    a_rdata <= attrs[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: if (walk == LAST_CELL) state_next = ST_IDLE;
      ST_IDLE: if (op_valid && rsp_free) state_next = ST_EXEC;
      ST_EXEC: begin
        case (cur.kind)
          OP_PUT:     state_next = (pos_inc == CELLS_S) ? ST_COPY : ST_IDLE;
          OP_NEWLINE: state_next = ST_FILL;
          OP_WIPE:    state_next = ST_WIPE;
          OP_SCROLL:  state_next = (shift_req == CELLS_S) ? ST_ZERO : ST_COPY;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        if (walk_inc == row_end) state_next = (row_end == CELLS_S) ? ST_COPY : ST_IDLE;
      end
      ST_WIPE:  if (walk == LAST_CELL) state_next = ST_IDLE;
      ST_COPY:  if (walk == LAST_CELL) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_ZERO;
      ST_ZERO:  if (walk == LAST_CELL) state_next = ST_IDLE;
      default:  state_next = ST_INIT;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_next        = cur;
    walk_next       = walk;
    shift_next      = shift;
    wrap_next       = wrap;
    pend_valid_next = 1'b0;
    pend_dst_next   = pend_dst;
    caret_pos_next  = caret_pos;
    caret_col_next  = caret_col;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    op_pop          = 1'b0;
    c_we            = 1'b0;
    c_waddr         = walk;
    c_wdata         = CHAR_BLANK;
    a_we            = 1'b0;
    a_waddr         = walk;
    a_wdata         = ATTR_DEFAULT;
    rd_addr         = walk;
    emit            = 1'b0;
    emit_char       = CHAR_BLANK;
    emit_attr       = CHAR_BLANK;

    case (state)
      ST_INIT, ST_WIPE: begin
        c_we      = 1'b1;
        c_wdata   = CHAR_SPACE;
        a_we      = 1'b1;
        walk_next = walk_inc[AW-1:0];
        if (state == ST_WIPE && walk == LAST_CELL) begin
          caret_pos_next = '0;
          caret_col_next = '0;
          emit           = 1'b1;
        end
      end
      ST_IDLE: begin
        // address the read port early so read data is ready in the next cycle
        rd_addr = head_idx_wide[AW-1:0];
        if (op_valid && rsp_free) begin
          op_pop   = 1'b1;
          cur_next = op_head;
        end
      end
      ST_EXEC: begin
        case (cur.kind)
          OP_PUT: begin
            c_we    = 1'b1;
            c_waddr = caret_pos;
            c_wdata = cur.char_code;
            a_we    = cur.colored;
            a_waddr = caret_pos;
            a_wdata = cur.color;
            if (pos_inc == CELLS_S) begin
              shift_next = ROW_SPAN;
              walk_next  = ROW_SPAN[AW-1:0];
              wrap_next  = 1'b1;
            end else begin
              caret_pos_next = pos_inc[AW-1:0];
              caret_col_next = col_inc;
              emit           = 1'b1;
            end
          end
          OP_NEWLINE: walk_next = caret_pos;
          OP_BACKSPACE: begin
            caret_pos_next = bs_pos;
            caret_col_next = bs_col;
            c_we           = 1'b1;
            c_waddr        = bs_pos;
            c_wdata        = CHAR_BLANK;
            emit           = 1'b1;
          end
          OP_WIPE: walk_next = '0;
          OP_SCROLL: begin
            shift_next = shift_req;
            wrap_next  = 1'b0;
            walk_next  = (shift_req == CELLS_S) ? '0 : shift_req[AW-1:0];
          end
          OP_READ: begin
            emit      = 1'b1;
            emit_char = cur.in_range ? c_rdata : CHAR_BLANK;
            emit_attr = cur.in_range ? a_rdata : CHAR_BLANK;
          end
          default: emit = 1'b1;
        endcase
      end
      ST_FILL: begin
        c_we      = 1'b1;
        c_wdata   = CHAR_SPACE;
        a_we      = cur.colored;
        a_wdata   = cur.color;
        walk_next = walk_inc[AW-1:0];
        if (walk_inc == row_end) begin
          if (row_end == CELLS_S) begin
            shift_next = ROW_SPAN;
            walk_next  = ROW_SPAN[AW-1:0];
            wrap_next  = 1'b1;
          end else begin
            caret_pos_next = row_end[AW-1:0];
            caret_col_next = '0;
            emit           = 1'b1;
          end
        end
      end
      ST_COPY: begin
        pend_valid_next = 1'b1;
        pend_dst_next   = walk - shift[AW-1:0];
        walk_next       = (walk == LAST_CELL) ? zero_start[AW-1:0] : walk_inc[AW-1:0];
      end
      ST_DRAIN: walk_next = walk;
      ST_ZERO: begin
        c_we      = 1'b1;
        c_wdata   = CHAR_BLANK;
        walk_next = walk_inc[AW-1:0];
        if (walk == LAST_CELL) begin
          if (wrap) begin
            caret_pos_next = LAST_ROW_START;
            caret_col_next = '0;
          end
          wrap_next = 1'b0;
          emit      = 1'b1;
        end
      end
      default: walk_next = '0;
    endcase

    // land the character that the copy walk fetched in the previous cycle
    if (pend_valid) begin
      c_we    = 1'b1;
      c_waddr = pend_dst;
      c_wdata = c_rdata;
    end

    if (emit) begin
      rsp_valid_next     = 1'b1;
      rsp_next.caret     = caret_wide[CARET_W-1:0];
      rsp_next.cell_char = emit_char;
      rsp_next.cell_attr = emit_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      walk       <= '0;
      wrap       <= 1'b0;
      pend_valid <= 1'b0;
      caret_pos  <= '0;
      caret_col  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      walk       <= walk_next;
      wrap       <= wrap_next;
      pend_valid <= pend_valid_next;
      caret_pos  <= caret_pos_next;
      caret_col  <= caret_col_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    shift    <= shift_next;
    pend_dst <= pend_dst_next;
    rsp      <= rsp_next;
  end

  `TCW_ASSERT_IMPLY(a_exec_out_empty, clk, rst, state == ST_EXEC, !rsp_valid, "result register busy at execute")
  `TCW_ASSERT_IMPLY(a_caret_range, clk, rst, 1'b1, caret_pos <= LAST_CELL, "caret beyond screen")
  `TCW_ASSERT_IMPLY(a_copy_window, clk, rst, pend_valid, state == ST_COPY || state == ST_DRAIN, "stray copy write")
  `TCW_ASSERT_NEXT(a_pop_to_exec, clk, rst, op_pop, state == ST_EXEC, "pop without execute")

endmodule

// ===== hdl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: a ROWS x COLUMNS screen of character and attribute
// cells with a caret, driven by one command item at a time.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload       | handshake
//   --------+-----------+---------------+-----------------------------------
//   req     | in        | tcw_pkg::req_t| req_valid / req_stall (block stalls)
//   rsp     | out       | tcw_pkg::rsp_t| rsp_valid / rsp_stall (sink stalls)
//
// Steps: the engine pops a plain or colored character, a backspace, a cell
// read or an ignored command and carries it out in its execute state. A
// newline pads the row with spaces from the caret up to the row end.
// Clear and scroll walk the whole character memory one cell per cycle;
// a write that runs off the last cell scrolls the screen up by one line.
// The single write port of the character memory paces these walks.
// Reset: a clearing pass over every cell fills the screen with spaces
// and attribute 0x07; req_stall stays high for its length.
// Stalls: a front register and a two-entry queue keep taking items, until
// both are full, while the engine is busy or a result waits in the output register.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tcw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tcw_pkg::rsp_t rsp
);
  import tcw_pkg::*;

  logic fe_valid;
  op_t  fe_op;
  logic q_full;
  logic q_valid;
  op_t  q_head;
  logic q_pop;
  logic init_busy;

  // accept and classify; hold intake off during the reset clearing pass
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .hold      (init_busy),
    .op_valid  (fe_valid),
    .op        (fe_op),
    .op_full   (q_full)
  );

  // decouple intake from the engine
  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fe_valid),
    .full       (q_full),
    .push_data  (fe_op),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  // carry out items against the screen memories
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op_head   (q_head),
    .op_pop    (q_pop),
    .init_busy (init_busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
